/* rtl/lru_tile_residency_cache_macros.svh */
// Assertion macros shared by the tile residency cache modules.
`ifndef LRU_TILE_RESIDENCY_CACHE_MACROS_SVH
`define LRU_TILE_RESIDENCY_CACHE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, ignored while arst_n is low.
`define LTRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define LTRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTRC_ASSERT(lbl, prop, msg)
`define LTRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/ltrc_pkg.sv */
// Shared constants and controller/datapath interface types for the tile residency cache.
package ltrc_pkg;

	localparam int MAX_TILES = 64;
	localparam int TILE_BITS = 10;

	localparam int IDX_W   = $clog2(MAX_TILES);
	localparam int FACE_W  = 3;
	localparam int KEY_W   = FACE_W + 2 * TILE_BITS;
	localparam int STAMP_W = 64;

	// Port field widths.
	localparam int CMD_W      = 1;
	localparam int OUT_SLOT_W = 6;
	localparam int COORD_W    = 10;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// Command field codes.
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch the request and restart the scan
		logic scan;    // read the slot under the scan index and advance it
		logic commit;  // update the tag store and load the result register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;  // scan index points at the last slot
	} dp_status_t;

endpackage

/* rtl/lru_tile_residency_cache.sv */
// Top level of the fully associative LRU tile residency cache.
//
// Input channel s_axis carries one request item: tuser holds the command (lookup or insert)
// and tdata holds the tile key (face, column, row). Output channel m_axis returns exactly
// one result item per request: hit flag, slot, eviction flag and the victim's key.
// Every request scans all 64 slots through one registered read port of the tag and
// stamp memories, one slot per cycle, to find a match, the lowest free slot and the
// least recently stamped entry. After the scan the controller passes through a drain
// step, which empties the read stage, and then a commit step that loads the result.
// The block accepts a new request only in its idle state, so it takes the next
// request only once the previous one has been committed.
// A result sits in an output register, so the next request is accepted and scanned while
// it waits. If the receiver still holds back the previous result when the next commit is
// due, the controller waits in its commit step until the output register is free.
// Reset clears all valid bits and the 64-bit use clock at once; the tag and stamp
// memories keep whatever they hold and are read only for valid slots, so no clearing
// pass is needed and the block accepts an item in the first cycle after reset.
module lru_tile_residency_cache (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: face [2:0], tile_x [12:3], tile_y [22:13], zero [23]
	input  logic [ltrc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// tuser: cmd [0]
	input  logic [ltrc_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata: hit [0], slot [6:1], evicted [7], victim_face [10:8], victim_x [20:11],
	// victim_y [30:21], zero [31]
	output logic [ltrc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	ltrc_pkg::ctrl_cmd_t  cmd;
	ltrc_pkg::dp_status_t sts;

	// The controller sequences the scan and owns both handshakes.
	ltrc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	// The datapath holds the tag store, the scan accumulators and the result register.
	ltrc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (s_axis_tdata),
		.req_cmd  (s_axis_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.res_data (m_axis_tdata)
	);

endmodule

/* rtl/ltrc_dp.sv */
// Datapath of the tile residency cache: tag and stamp memories, scan, and update.
`include "lru_tile_residency_cache_macros.svh"

module ltrc_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [ltrc_pkg::IN_DATA_W-1:0]     req_data,
	input  logic [ltrc_pkg::CMD_W-1:0]         req_cmd,
	input  ltrc_pkg::ctrl_cmd_t                cmd,
	output ltrc_pkg::dp_status_t               sts,
	output logic [ltrc_pkg::OUT_DATA_W-1:0]    res_data
);

	localparam int IW = ltrc_pkg::IDX_W;
	localparam int KW = ltrc_pkg::KEY_W;
	localparam int SW = ltrc_pkg::STAMP_W;
	localparam int TB = ltrc_pkg::TILE_BITS;
	localparam int FW = ltrc_pkg::FACE_W;
	localparam int CW = ltrc_pkg::COORD_W;

	// Tag and stamp memories; contents are meaningful only where valid_q is set.
	logic [KW-1:0] key_mem   [ltrc_pkg::MAX_TILES];
	logic [SW-1:0] stamp_mem [ltrc_pkg::MAX_TILES];
	logic [ltrc_pkg::MAX_TILES-1:0] valid_q;

	logic [KW-1:0]                  req_key_q;
	logic [ltrc_pkg::CMD_W-1:0]     req_cmd_q;
	logic [IW-1:0]                  idx_q;
	logic [SW-1:0]                  use_clock_q;

	// Read stage of the scan.
	logic                           cmp_en_s1;
	logic [IW-1:0]                  idx_s1;
	logic                           valid_s1;
	logic [KW-1:0]                  key_s1;
	logic [SW-1:0]                  stamp_s1;

	// Scan results.
	logic                           match_found_q;
	logic [IW-1:0]                  match_idx_q;
	logic                           free_found_q;
	logic [IW-1:0]                  free_idx_q;
	logic                           oldest_found_q;
	logic [IW-1:0]                  oldest_idx_q;
	logic [SW-1:0]                  oldest_stamp_q;
	logic [KW-1:0]                  oldest_key_q;

	logic [KW-1:0]                  new_key;
	logic                           is_insert;
	logic                           do_touch;
	logic                           do_fill;
	logic                           do_evict;
	logic [IW-1:0]                  wr_idx;
	logic [SW-1:0]                  next_clock;
	logic                           hit_d;
	logic [IW-1:0]                  slot_d;
	logic [FW-1:0]                  vface_d;
	logic [TB-1:0]                  vx_d;
	logic [TB-1:0]                  vy_d;

	// Key layout: face above column above row, coordinates masked to TILE_BITS.
	assign new_key = {req_data[FW-1:0], req_data[FW+TB-1:FW], req_data[FW+CW+TB-1:FW+CW]};

	assign is_insert  = (req_cmd_q == ltrc_pkg::CMD_INSERT);
	assign do_touch   = match_found_q || is_insert;
	assign do_fill    = !match_found_q && is_insert;
	assign do_evict   = do_fill && !free_found_q;
	assign next_clock = use_clock_q + SW'(1);
	assign sts.idx_last = (idx_q == IW'(ltrc_pkg::MAX_TILES - 1));

	always_comb begin
		if (match_found_q) begin
			wr_idx = match_idx_q;
		end else if (free_found_q) begin
			wr_idx = free_idx_q;
		end else begin
			wr_idx = oldest_idx_q;
		end
	end

	always_comb begin
		hit_d   = match_found_q;
		slot_d  = do_touch ? wr_idx : '0;
		vface_d = '0;
		vx_d    = '0;
		vy_d    = '0;
		if (do_evict) begin
			vface_d = oldest_key_q[KW-1 -: FW];
			vx_d    = oldest_key_q[2*TB-1 -: TB];
			vy_d    = oldest_key_q[TB-1:0];
		end
	end

	// Memories: one write port at commit, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (cmd.commit && do_fill) begin
			key_mem[wr_idx] <= req_key_q;
		end
		if (cmd.commit && do_touch) begin
			stamp_mem[wr_idx] <= next_clock;
		end
		key_s1   <= key_mem[idx_q];
		stamp_s1 <= stamp_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			use_clock_q <= '0;
			idx_q       <= '0;
			cmp_en_s1   <= 1'b0;
		end else begin
			cmp_en_s1 <= cmd.scan;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.commit && do_touch) begin
				use_clock_q <= next_clock;
			end
			if (cmd.commit && do_fill) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Request and scan bookkeeping registers.
	always_ff @(posedge clk) begin
		idx_s1   <= idx_q;
		valid_s1 <= valid_q[idx_q];
		if (cmd.load) begin
			req_key_q      <= new_key;
			req_cmd_q      <= req_cmd;
			match_found_q  <= 1'b0;
			free_found_q   <= 1'b0;
			oldest_found_q <= 1'b0;
		end else if (cmp_en_s1) begin
			if (valid_s1) begin
				if (!match_found_q && key_s1 == req_key_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
				end
				// Strict compare keeps the lowest slot among equal stamps.
				if (!oldest_found_q || stamp_s1 < oldest_stamp_q) begin
					oldest_found_q <= 1'b1;
					oldest_idx_q   <= idx_s1;
					oldest_stamp_q <= stamp_s1;
					oldest_key_q   <= key_s1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
		if (cmd.commit) begin
			res_data <= {1'b0,
				CW'(vy_d), CW'(vx_d), vface_d, do_evict,
				ltrc_pkg::OUT_SLOT_W'(slot_d), hit_d};
		end
	end

	`LTRC_ASSERT(a_evict_has_oldest, (cmd.commit && do_evict) |-> oldest_found_q,
		"eviction without an oldest entry")
	`LTRC_ASSERT(a_clock_step, (cmd.commit && do_touch) |=> (use_clock_q == $past(next_clock)),
		"use clock did not advance on a touch")
	`LTRC_ASSERT(a_miss_keeps_clock, (cmd.commit && !do_touch) |=> $stable(use_clock_q),
		"use clock moved on a lookup miss")

endmodule

/* rtl/ltrc_ctrl.sv */
// Controller of the tile residency cache: scan sequencing and stream handshakes.
`include "lru_tile_residency_cache_macros.svh"

module ltrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output ltrc_pkg::ctrl_cmd_t   cmd,
	input  ltrc_pkg::dp_status_t  sts
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   room;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign room          = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (room) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LTRC_ASSERT(a_commit_room, cmd.commit |-> room, "result register overwritten")
	`LTRC_ASSERT(a_commit_shows, cmd.commit |=> m_axis_tvalid, "commit did not present a result")
	`LTRC_ASSERT(a_drain_after_last, (state_q == ST_DRAIN) |-> $past(sts.idx_last),
		"scan ended before the last slot")

endmodule
